@@ rtl/core/irpd_pkg.sv @@
// Package for the IR remote pulse decoder: word types, register indexes,
// reset values and frame constants. No dependencies.

package irpd_pkg;

  // Field widths
  localparam int TIME_W     = 16;
  localparam int CODE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int EDGE_IDX_W = 5;

  // Frame layout: one start pulse, eight spaces, data widths in between
  localparam int FRAME_EDGES = 18;
  localparam int SPACE_COUNT = 8;
  localparam int CODE_BITS   = 7;

  // Kind of input word
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register reset values
  localparam logic [TIME_W-1:0] START_MIN_RST     = 16'd2000;
  localparam logic [TIME_W-1:0] SPACE_MIN_RST     = 16'd300;
  localparam logic [TIME_W-1:0] SPACE_MAX_RST     = 16'd600;
  localparam logic [TIME_W-1:0] ONE_THRESHOLD_RST = 16'd1000;
  localparam logic [TIME_W-1:0] TIMEOUT_TICKS_RST = 16'd32768;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MIN     = 3'd0,
    REG_SPACE_MIN     = 3'd1,
    REG_SPACE_MAX     = 3'd2,
    REG_ONE_THRESHOLD = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } reg_idx_t;

  // Input word
  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] edge_time;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              timed_out;
  } out_word_t;

  // Register file contents handed to the decoder
  typedef struct packed {
    logic [TIME_W-1:0] start_min;
    logic [TIME_W-1:0] space_min;
    logic [TIME_W-1:0] space_max;
    logic [TIME_W-1:0] one_threshold;
    logic [TIME_W-1:0] timeout_ticks;
  } cfg_regs_t;

endpackage

@@ rtl/core/irpd_cfg.sv @@
// Configuration register file of the IR remote pulse decoder.
// Depends on irpd_pkg.

module irpd_cfg import irpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_min     <= START_MIN_RST;
      regs_r.space_min     <= SPACE_MIN_RST;
      regs_r.space_max     <= SPACE_MAX_RST;
      regs_r.one_threshold <= ONE_THRESHOLD_RST;
      regs_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_MIN:     regs_r.start_min     <= cfg_wdata;
        REG_SPACE_MIN:     regs_r.space_min     <= cfg_wdata;
        REG_SPACE_MAX:     regs_r.space_max     <= cfg_wdata;
        REG_ONE_THRESHOLD: regs_r.one_threshold <= cfg_wdata;
        REG_TIMEOUT_TICKS: regs_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/irpd_step.sv @@
// Frame state and single-step decode logic of the IR remote pulse decoder.
// Depends on irpd_pkg.

module irpd_step import irpd_pkg::*; #(
  parameter int NUM_CODE_BITS = CODE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,      // process word_in this cycle
  input  in_word_t  word_in,
  input  cfg_regs_t regs,
  output logic      res_vld,
  output out_word_t res_word
);

  logic [EDGE_IDX_W-1:0]    edge_idx_r, edge_idx_nxt;
  logic [TIME_W-1:0]        prev_time_r, prev_time_nxt;
  logic                     frame_ok_r, frame_ok_nxt;
  logic [NUM_CODE_BITS-1:0] code_bits_r, code_bits_nxt;
  logic [TIME_W-1:0]        tick_cnt_r, tick_cnt_nxt;

  logic [TIME_W-1:0]        tick_inc;
  logic [TIME_W-1:0]        width;
  logic [EDGE_IDX_W-1:0]    wnum;
  logic [EDGE_IDX_W-1:0]    idx_inc;
  logic [EDGE_IDX_W-2:0]    bit_idx;
  logic                     space_bad;
  logic                     data_slot;
  logic                     is_one;
  logic [NUM_CODE_BITS-1:0] bits_set;
  logic [CODE_W-1:0]        code_ext;

  // Width of the pulse that ends at this edge, modulo 2^16
  assign tick_inc = tick_cnt_r + 1'b1;
  assign width    = word_in.edge_time - prev_time_r;
  assign wnum     = edge_idx_r - 1'b1;
  assign idx_inc  = edge_idx_r + 1'b1;
  assign bit_idx  = wnum[EDGE_IDX_W-1:1] - 1'b1;

  // Odd widths up to the last space are checked against the window
  assign space_bad = wnum[0] &&
                     (wnum <= EDGE_IDX_W'(2 * SPACE_COUNT - 1)) &&
                     ((width < regs.space_min) || (width > regs.space_max));
  assign data_slot = !wnum[0] && (wnum != '0);
  assign is_one    = width >= regs.one_threshold;

  // Data bit set for this edge, LSB first
  always_comb begin
    bits_set = code_bits_r;
    for (int i = 0; i < NUM_CODE_BITS; i++) begin
      if (data_slot && is_one && (bit_idx == (EDGE_IDX_W-1)'(i)))
        bits_set[i] = 1'b1;
    end
  end

  always_comb begin
    code_ext = '0;
    code_ext[NUM_CODE_BITS-1:0] = bits_set;
  end

  // Next state and result
  always_comb begin
    edge_idx_nxt  = edge_idx_r;
    prev_time_nxt = prev_time_r;
    frame_ok_nxt  = frame_ok_r;
    code_bits_nxt = code_bits_r;
    tick_cnt_nxt  = tick_cnt_r;
    res_vld       = 1'b0;
    res_word      = '0;
    if (word_in.kind == KIND_TICK) begin
      tick_cnt_nxt = tick_inc;
      if ((tick_inc >= regs.timeout_ticks) || (tick_inc == '0)) begin
        // timeout: report and start a new attempt
        edge_idx_nxt       = '0;
        tick_cnt_nxt       = '0;
        frame_ok_nxt       = 1'b1;
        code_bits_nxt      = '0;
        res_vld            = 1'b1;
        res_word.timed_out = 1'b1;
      end
    end else if (edge_idx_r == '0) begin
      // first edge only stamps the time
      prev_time_nxt = word_in.edge_time;
      edge_idx_nxt  = EDGE_IDX_W'(1);
    end else begin
      prev_time_nxt = word_in.edge_time;
      edge_idx_nxt  = idx_inc;
      code_bits_nxt = bits_set;
      if ((wnum == '0) && (width < regs.start_min))
        frame_ok_nxt = 1'b0;
      if (space_bad)
        frame_ok_nxt = 1'b0;
      if (idx_inc >= EDGE_IDX_W'(FRAME_EDGES)) begin
        // frame complete: emit only if every check passed
        res_vld       = frame_ok_r && !space_bad;
        res_word.code = code_ext;
        edge_idx_nxt  = '0;
        tick_cnt_nxt  = '0;
        frame_ok_nxt  = 1'b1;
        code_bits_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_idx_r  <= '0;
      prev_time_r <= '0;
      frame_ok_r  <= 1'b1;
      code_bits_r <= '0;
      tick_cnt_r  <= '0;
    end else if (step) begin
      edge_idx_r  <= edge_idx_nxt;
      prev_time_r <= prev_time_nxt;
      frame_ok_r  <= frame_ok_nxt;
      code_bits_r <= code_bits_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
    end
  end

endmodule

@@ rtl/core/ir_remote_pulse_decoder.sv @@
// IR remote pulse decoder: takes one word (edge timestamp or timeout tick)
// per clock while in_stall is low and returns a decoded code or a timeout
// word. Throughput is one word per cycle while out_stall is low; a word
// passes through the input register and is decoded in a single step into
// the result register, from which any result is offered on out_valid. The
// decode step (one subtract, a few compares) sets the cycle. A word is held
// in the input register while a result waits under out_stall, so in_stall
// follows out_stall in the same cycle.
// Depends on irpd_pkg, irpd_cfg and irpd_step.

module ir_remote_pulse_decoder import irpd_pkg::*; #(
  parameter int NUM_CODE_BITS = CODE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata
);

  cfg_regs_t regs;
  logic      in_vld_r, in_vld_nxt;
  in_word_t  in_word_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_word_r;
  logic      adv;
  logic      res_vld;
  out_word_t res_word;
  logic      in_take;

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  irpd_step #(
    .NUM_CODE_BITS (NUM_CODE_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .word_in  (in_word_r),
    .regs     (regs),
    .res_vld  (res_vld),
    .res_word (res_word)
  );

  // Held word moves on when the result register has room
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take)
      in_vld_nxt = 1'b1;
    else if (adv)
      in_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && res_vld)
      out_vld_nxt = 1'b1;
    else if (!out_stall)
      out_vld_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take)
      in_word_r <= in_data;
    if (adv && res_vld)
      out_word_r <= res_word;
  end

endmodule
